FILE: design/macd_pkg.sv
// shared constants, types and cross codes for the moving average cross detector
`default_nettype none

package macd_pkg;

   // default window depths and price width
   localparam int SHORT_WINDOW_DEF = 5;
   localparam int LONG_WINDOW_DEF  = 10;
   localparam int PRICE_BITS_DEF   = 32;

   // fixed transaction field widths
   localparam int CLOSE_PRICE_BITS = 32;
   localparam int SHORT_SUM_BITS   = 35;
   localparam int LONG_SUM_BITS    = 36;

   // cross indication codes
   typedef enum logic [1:0] {
      CROSS_NONE   = 2'd0,
      CROSS_GOLDEN = 2'd1,
      CROSS_DEAD   = 2'd2
   } cross_type;

   // status of one price update, from the window unit to the cross logic
   typedef struct packed {
      logic ready;
      logic short_up;
      logic long_up;
      logic above_prev;
   } window_flags_type;

endpackage

`default_nettype wire

FILE: design/macd_if.sv
// valid/ready channel interfaces for price requests and cross responses
`default_nettype none

interface macd_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [macd_pkg::CLOSE_PRICE_BITS-1:0] close_price;
   logic                                  restart;

   modport source (output valid, output close_price, output restart, input ready);
   modport sink   (input valid, input close_price, input restart, output ready);
endinterface

interface macd_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                ready_res;
   logic [1:0]                          cross_signal;
   logic [macd_pkg::SHORT_SUM_BITS-1:0] short_sum;
   logic [macd_pkg::LONG_SUM_BITS-1:0]  long_sum;

   modport source (output valid, output ready_res, output cross_signal,
                   output short_sum, output long_sum, input ready);
   modport sink   (input valid, input ready_res, input cross_signal,
                   input short_sum, input long_sum, output ready);
endinterface

`default_nettype wire

FILE: design/macd_window.sv
// price delay line, running window sums, sample count and previous above flag
`default_nettype none

module macd_window #(
   parameter int SHORT_WINDOW = macd_pkg::SHORT_WINDOW_DEF,
   parameter int LONG_WINDOW  = macd_pkg::LONG_WINDOW_DEF,
   parameter int PRICE_BITS   = macd_pkg::PRICE_BITS_DEF,
   localparam int SS_BITS     = PRICE_BITS + $clog2(SHORT_WINDOW + 1),
   localparam int LS_BITS     = PRICE_BITS + $clog2(LONG_WINDOW + 1)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          update,
   input  wire logic [PRICE_BITS-1:0]         price,
   input  wire logic                          restart,
   input  wire logic                          above_now,
   output logic [SS_BITS-1:0]                 short_sum_next,
   output logic [LS_BITS-1:0]                 long_sum_next,
   output macd_pkg::window_flags_type         flags
);

   localparam int HIST_DEPTH  = (SHORT_WINDOW > LONG_WINDOW) ? SHORT_WINDOW : LONG_WINDOW;
   localparam int READY_COUNT = HIST_DEPTH + 1;
   localparam int CNT_BITS    = $clog2(READY_COUNT + 1);

   logic [PRICE_BITS-1:0] hist_ff [HIST_DEPTH];
   logic [SS_BITS-1:0]    short_sum_ff;
   logic [LS_BITS-1:0]    long_sum_ff;
   logic [CNT_BITS-1:0]   count_ff;
   logic                  above_ff;

   logic [SS_BITS-1:0]    short_base;
   logic [LS_BITS-1:0]    long_base;
   logic [PRICE_BITS-1:0] short_oldest;
   logic [PRICE_BITS-1:0] long_oldest;
   logic [CNT_BITS-1:0]   count_base;
   logic [CNT_BITS-1:0]   count_in;

   // a restart makes the item see a cleared series
   always_comb begin
      short_base   = restart ? '0 : short_sum_ff;
      long_base    = restart ? '0 : long_sum_ff;
      short_oldest = restart ? '0 : hist_ff[SHORT_WINDOW-1];
      long_oldest  = restart ? '0 : hist_ff[LONG_WINDOW-1];
      count_base   = restart ? '0 : count_ff;
   end

   // running sums: add the newest price, drop the one leaving the window
   always_comb begin
      short_sum_next = short_base - SS_BITS'(short_oldest) + SS_BITS'(price);
      long_sum_next  = long_base - LS_BITS'(long_oldest) + LS_BITS'(price);
   end

   // saturating sample count
   always_comb begin
      if (count_base < CNT_BITS'(READY_COUNT)) begin
         count_in = count_base + CNT_BITS'(1);
      end else begin
         count_in = count_base;
      end
   end

   // a sum rises exactly when the new price beats the one it replaces
   always_comb begin
      flags.ready      = (count_in == CNT_BITS'(READY_COUNT));
      flags.short_up   = (price > short_oldest);
      flags.long_up    = (price > long_oldest);
      flags.above_prev = restart ? 1'b0 : above_ff;
   end

   // state update per transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < HIST_DEPTH; k++) begin
            hist_ff[k] <= '0;
         end
         short_sum_ff <= '0;
         long_sum_ff  <= '0;
         count_ff     <= '0;
         above_ff     <= 1'b0;
      end else if (update) begin
         hist_ff[0] <= price;
         for (int k = 1; k < HIST_DEPTH; k++) begin
            hist_ff[k] <= restart ? '0 : hist_ff[k-1];
         end
         short_sum_ff <= short_sum_next;
         long_sum_ff  <= long_sum_next;
         count_ff     <= count_in;
         above_ff     <= above_now;
      end
   end

endmodule

`default_nettype wire

FILE: design/macd_cross.sv
// average comparison by cross multiplication and golden/dead cross decision
`default_nettype none

module macd_cross #(
   parameter int SHORT_WINDOW = macd_pkg::SHORT_WINDOW_DEF,
   parameter int LONG_WINDOW  = macd_pkg::LONG_WINDOW_DEF,
   parameter int PRICE_BITS   = macd_pkg::PRICE_BITS_DEF,
   localparam int SS_BITS     = PRICE_BITS + $clog2(SHORT_WINDOW + 1),
   localparam int LS_BITS     = PRICE_BITS + $clog2(LONG_WINDOW + 1)
) (
   input  wire logic [SS_BITS-1:0]            short_sum,
   input  wire logic [LS_BITS-1:0]            long_sum,
   input  wire macd_pkg::window_flags_type    flags,
   output logic                               above_now,
   output macd_pkg::cross_type                cross_code
);

   localparam int PS_BITS   = SS_BITS + $clog2(LONG_WINDOW + 1);
   localparam int PL_BITS   = LS_BITS + $clog2(SHORT_WINDOW + 1);
   localparam int PROD_BITS = (PS_BITS > PL_BITS) ? PS_BITS : PL_BITS;

   logic [PROD_BITS-1:0] short_scaled;
   logic [PROD_BITS-1:0] long_scaled;

   // short average above long average without dividing
   always_comb begin
      short_scaled = PROD_BITS'(short_sum) * PROD_BITS'(LONG_WINDOW);
      long_scaled  = PROD_BITS'(long_sum) * PROD_BITS'(SHORT_WINDOW);
      above_now    = (short_scaled > long_scaled);
   end

   // cross decision, only once the series is long enough
   always_comb begin
      cross_code = macd_pkg::CROSS_NONE;
      if (flags.ready) begin
         if (above_now && !flags.above_prev && flags.short_up && flags.long_up) begin
            cross_code = macd_pkg::CROSS_GOLDEN;
         end else if (!above_now && flags.above_prev && !flags.short_up &&
                      !flags.long_up) begin
            cross_code = macd_pkg::CROSS_DEAD;
         end
      end
   end

endmodule

`default_nettype wire

FILE: design/moving_average_cross_detector.sv
// top level: input register, window update, cross decision and result register
//
// Moving average cross detector. Each request transaction on req_chan carries one
// closing price (unsigned ticks, low PRICE_BITS bits used) and a restart flag that
// begins a new series. Each request yields exactly one response transaction on
// rsp_chan with the 5-sample and 10-sample window sums, a ready flag (eleven or
// more prices in the series) and a cross code: none, golden cross or dead cross.
// A taken request loads the input register, and its result then the result
// register. Throughput: one transaction per cycle while rsp_chan.ready is
// high; the per-price window update is a single add/subtract pass plus a
// constant-multiply compare between the two registers.
// Reset clears the price history, sums, sample count and both valid flags.
// When the receiver stalls, the result register holds its response and the input
// register can still take one more request; after that req_chan.ready drops until
// the response is taken.
`default_nettype none

module moving_average_cross_detector #(
   parameter int SHORT_WINDOW = macd_pkg::SHORT_WINDOW_DEF,
   parameter int LONG_WINDOW  = macd_pkg::LONG_WINDOW_DEF,
   parameter int PRICE_BITS   = macd_pkg::PRICE_BITS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   macd_req_if.sink   req_chan,
   macd_rsp_if.source rsp_chan
);

   localparam int SS_BITS  = PRICE_BITS + $clog2(SHORT_WINDOW + 1);
   localparam int LS_BITS  = PRICE_BITS + $clog2(LONG_WINDOW + 1);
   localparam int EXT_BITS = (PRICE_BITS > macd_pkg::CLOSE_PRICE_BITS) ?
                             PRICE_BITS : macd_pkg::CLOSE_PRICE_BITS;

   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   logic [PRICE_BITS-1:0] s1_price_ff;
   logic                  s1_restart_ff;

   logic                                 rsp_valid_ff;
   logic                                 rsp_valid_in;
   logic                                 rsp_ready_res_ff;
   macd_pkg::cross_type                  rsp_cross_ff;
   logic [macd_pkg::SHORT_SUM_BITS-1:0]  rsp_short_sum_ff;
   logic [macd_pkg::LONG_SUM_BITS-1:0]   rsp_long_sum_ff;

   logic                       req_accept;
   logic                       advance;
   logic [EXT_BITS-1:0]        price_ext;
   logic [SS_BITS-1:0]         short_sum_next;
   logic [LS_BITS-1:0]         long_sum_next;
   logic                       above_now;
   macd_pkg::window_flags_type flags;
   macd_pkg::cross_type        cross_code;

   // handshake control
   assign advance          = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready   = !s1_valid_ff || advance;
   assign req_accept       = req_chan.valid && req_chan.ready;
   assign price_ext        = EXT_BITS'(req_chan.close_price);

   always_comb begin
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_price_ff   <= price_ext[PRICE_BITS-1:0];
         s1_restart_ff <= req_chan.restart;
      end
   end

   // window state and sums
   macd_window #(
      .SHORT_WINDOW (SHORT_WINDOW),
      .LONG_WINDOW  (LONG_WINDOW),
      .PRICE_BITS   (PRICE_BITS)
   ) u_window (
      .clock          (clock),
      .reset          (reset),
      .update         (advance),
      .price          (s1_price_ff),
      .restart        (s1_restart_ff),
      .above_now      (above_now),
      .short_sum_next (short_sum_next),
      .long_sum_next  (long_sum_next),
      .flags          (flags)
   );

   // cross decision
   macd_cross #(
      .SHORT_WINDOW (SHORT_WINDOW),
      .LONG_WINDOW  (LONG_WINDOW),
      .PRICE_BITS   (PRICE_BITS)
   ) u_cross (
      .short_sum  (short_sum_next),
      .long_sum   (long_sum_next),
      .flags      (flags),
      .above_now  (above_now),
      .cross_code (cross_code)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ready_res_ff <= flags.ready;
         rsp_cross_ff     <= cross_code;
         rsp_short_sum_ff <= macd_pkg::SHORT_SUM_BITS'(short_sum_next);
         rsp_long_sum_ff  <= macd_pkg::LONG_SUM_BITS'(long_sum_next);
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.ready_res    = rsp_ready_res_ff;
   assign rsp_chan.cross_signal = rsp_cross_ff;
   assign rsp_chan.short_sum    = rsp_short_sum_ff;
   assign rsp_chan.long_sum     = rsp_long_sum_ff;

   // a cross is only ever reported on a ready series
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_cross_ff != macd_pkg::CROSS_NONE)) |-> rsp_ready_res_ff)
      else $error("cross reported before series is ready");

   // a restarted series is never ready on its first price
   assert property (@(posedge clock) disable iff (reset)
      (advance && s1_restart_ff) |=> !rsp_ready_res_ff)
      else $error("ready flag set right after restart");

   // an accepted transaction always lands in the input register
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted transaction lost");

   // the input register is never overwritten while it still holds a transaction
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |-> !req_accept)
      else $error("input register overwritten");

endmodule

`default_nettype wire

FILE: bench/moving_average_cross_detector_tb.sv
// testbench for the moving average cross detector: random price series, predictor, checker
module moving_average_cross_detector_tb;

   localparam int HIST_DEPTH  = (macd_pkg::SHORT_WINDOW_DEF > macd_pkg::LONG_WINDOW_DEF) ?
                                macd_pkg::SHORT_WINDOW_DEF : macd_pkg::LONG_WINDOW_DEF;
   localparam int READY_COUNT = HIST_DEPTH + 1;
   localparam longint unsigned PRICE_MASK = (64'd1 << macd_pkg::PRICE_BITS_DEF) - 64'd1;
   localparam int ITEM_TOTAL  = 1725;
   localparam int SETTLE_CYCLES = 10;

   typedef struct {
      logic [macd_pkg::CLOSE_PRICE_BITS-1:0] price;
      logic                                  restart;
      int                                    gap;
      bit                                    drain;
   } price_item_type;

   typedef struct {
      logic                                ready_res;
      macd_pkg::cross_type                 cross_code;
      logic [macd_pkg::SHORT_SUM_BITS-1:0] short_sum;
      logic [macd_pkg::LONG_SUM_BITS-1:0]  long_sum;
   } cross_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                  req_valid = 1'b0;
   logic [macd_pkg::CLOSE_PRICE_BITS-1:0] req_close_price = '0;
   logic                                  req_restart = 1'b0;
   logic                                  rsp_ready = 1'b0;

   macd_req_if req_chan ();
   macd_rsp_if rsp_chan ();

   assign req_chan.valid       = req_valid;
   assign req_chan.close_price = req_close_price;
   assign req_chan.restart     = req_restart;
   assign rsp_chan.ready       = rsp_ready;

   moving_average_cross_detector uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // clock and reset
   always #5 clock = ~clock;

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // pending prices, expected results and progress counters
   price_item_type   price_queue[$];
   cross_result_type expected_results[$];
   int req_taken = 0;
   int rsp_taken = 0;
   int mismatches = 0;

   // predictor state
   longint unsigned price_line[HIST_DEPTH];
   longint unsigned short_total, long_total, last_short_total, last_long_total;
   int              series_count;

   function automatic void clear_series();
      for (int k = 0; k < HIST_DEPTH; k++) price_line[k] = 0;
      short_total = 0;
      long_total = 0;
      last_short_total = 0;
      last_long_total = 0;
      series_count = 0;
   endfunction

   function automatic bit short_above(longint unsigned s, longint unsigned l);
      return s * macd_pkg::LONG_WINDOW_DEF > l * macd_pkg::SHORT_WINDOW_DEF;
   endfunction

   // one price in, one expected result out
   function automatic cross_result_type track_price(
         logic [macd_pkg::CLOSE_PRICE_BITS-1:0] close_price, logic restart);
      cross_result_type res;
      longint unsigned  price;
      bit above_now, above_prev, short_up, long_up;
      price = longint'(close_price) & PRICE_MASK;
      if (restart) clear_series();
      last_short_total = short_total;
      last_long_total = long_total;
      short_total = short_total + price - price_line[macd_pkg::SHORT_WINDOW_DEF-1];
      long_total = long_total + price - price_line[macd_pkg::LONG_WINDOW_DEF-1];
      for (int k = HIST_DEPTH - 1; k > 0; k--) price_line[k] = price_line[k-1];
      price_line[0] = price;
      if (series_count < READY_COUNT) series_count++;
      res.ready_res = (series_count >= READY_COUNT);
      res.cross_code = macd_pkg::CROSS_NONE;
      if (res.ready_res) begin
         above_now = short_above(short_total, long_total);
         above_prev = short_above(last_short_total, last_long_total);
         short_up = short_total > last_short_total;
         long_up = long_total > last_long_total;
         if (above_now && !above_prev && short_up && long_up)
            res.cross_code = macd_pkg::CROSS_GOLDEN;
         else if (!above_now && above_prev && !short_up && !long_up)
            res.cross_code = macd_pkg::CROSS_DEAD;
      end
      res.short_sum = short_total[macd_pkg::SHORT_SUM_BITS-1:0];
      res.long_sum = long_total[macd_pkg::LONG_SUM_BITS-1:0];
      return res;
   endfunction

   // idle length: mostly short, a few long
   function automatic int pick_gap(bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic void queue_price(longint unsigned price, logic restart, int gap,
                                       bit drain);
      price_item_type it;
      it.price = price[macd_pkg::CLOSE_PRICE_BITS-1:0];
      it.restart = restart;
      it.gap = gap;
      it.drain = drain;
      price_queue.push_back(it);
   endfunction

   task automatic flag_mismatch(string field, longint unsigned want, logic [63:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch in %s at response %0d: expected %0h, got %0h",
                  field, rsp_taken, want, got);
   endtask

   // request driver
   int drv_gap_left = 0;
   bit drv_gap_loaded = 1'b0;

   always @(posedge clock) begin
      price_item_type it;
      logic           offer;
      offer = 1'b0;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_chan.ready) begin
         if (price_queue.size() != 0) begin
            if (!drv_gap_loaded) begin
               drv_gap_left = price_queue[0].gap;
               drv_gap_loaded = 1'b1;
            end
            if (drv_gap_left > 0)
               drv_gap_left--;
            else if (!price_queue[0].drain || (!req_valid && req_taken == rsp_taken))
               offer = 1'b1;
         end
         if (offer) begin
            it = price_queue.pop_front();
            drv_gap_loaded = 1'b0;
            req_close_price <= it.price;
            req_restart <= it.restart;
         end
         req_valid <= offer;
      end
   end

   // response receiver with random stalls and one long hold-off
   int  rx_stall_left = 0;
   int  rx_hold_left = 0;
   bit  rx_hold_done = 1'b0;
   bit  rx_quiet = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if ($urandom_range(399) == 0) rx_quiet = !rx_quiet;
         if (!rx_hold_done && req_taken >= 400) begin
            rx_hold_left = 300;
            rx_hold_done = 1'b1;
         end
         if (rx_hold_left > 0) begin
            rx_hold_left--;
            rsp_ready <= 1'b0;
         end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(99) < 35) rx_stall_left = pick_gap(rx_quiet);
         end
      end
   end

   // monitor: check responses, then predict accepted requests
   always @(posedge clock) begin
      cross_result_type want;
      if (reset) begin
         clear_series();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_results.size() == 0) begin
               flag_mismatch("unexpected response", 0, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_chan.ready_res !== want.ready_res)
                  flag_mismatch("ready_res", want.ready_res, rsp_chan.ready_res);
               if (rsp_chan.cross_signal !== want.cross_code)
                  flag_mismatch("cross_signal", want.cross_code, rsp_chan.cross_signal);
               if (rsp_chan.short_sum !== want.short_sum)
                  flag_mismatch("short_sum", want.short_sum, rsp_chan.short_sum);
               if (rsp_chan.long_sum !== want.long_sum)
                  flag_mismatch("long_sum", want.long_sum, rsp_chan.long_sum);
            end
            rsp_taken <= rsp_taken + 1;
         end
         if (req_chan.valid && req_chan.ready) begin
            expected_results.push_back(track_price(req_chan.close_price, req_chan.restart));
            req_taken <= req_taken + 1;
         end
      end
   end

   // stimulus and end of run
   initial begin
      longint          p, v, jitter;
      int unsigned     scale;
      int              len, burst, total;
      bit              quiet, flat, drain;

      // full-scale prices through the first ready point
      queue_price(64'hFFFF_FFFF, 1'b1, 0, 1'b0);
      for (int k = 0; k < 10; k++) queue_price(64'hFFFF_FFFF, 1'b0, 0, 1'b0);
      // flat series (equal averages), then a jump for a golden cross and a drop for a dead one
      queue_price(1000, 1'b1, 0, 1'b1);
      for (int k = 0; k < 9; k++) queue_price(1000, 1'b0, 0, 1'b0);
      queue_price(2000, 1'b0, 0, 1'b0);
      queue_price(0, 1'b0, 0, 1'b0);
      queue_price(0, 1'b0, 0, 1'b0);
      // restart mid-series with a zero price
      queue_price(0, 1'b1, 1, 1'b0);

      while (price_queue.size() < ITEM_TOTAL) begin
         quiet = ($urandom_range(3) == 0);
         if ($urandom_range(99) < 12) begin
            // noise: raw prices and stray restarts
            burst = $urandom_range(8, 1);
            for (int k = 0; k < burst; k++)
               queue_price($urandom, $urandom_range(3) == 0, pick_gap(quiet), 1'b0);
         end else begin
            // trending series with turning points
            len = $urandom_range(60, 12);
            case ($urandom_range(3))
               0: scale = $urandom_range(16, 1);
               1: scale = $urandom_range(4096, 1);
               2: scale = $urandom_range(1 << 20, 1);
               default: scale = $urandom_range(1 << 28, 1 << 24);
            endcase
            case ($urandom_range(3))
               0: p = $urandom_range(255);
               1: p = 64'hFFFF_FFFF - $urandom_range(255);
               default: p = $urandom;
            endcase
            flat = ($urandom_range(19) == 0);
            v = flat ? 0 : ($urandom_range(1) ? longint'(scale) : -longint'(scale));
            drain = ($urandom_range(9) == 0);
            for (int k = 0; k < len; k++) begin
               queue_price(p, k == 0 || $urandom_range(39) == 0, pick_gap(quiet),
                           drain && k == 0);
               if ($urandom_range(7) == 0) v = -v;
               jitter = flat ? 0 : longint'($urandom_range(scale)) - longint'(scale / 2);
               p = p + v + jitter;
               if (p < 0) p = 0;
               if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
            end
         end
      end
      total = price_queue.size();

      wait (rsp_taken == total);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         $display("%0d expected responses never arrived", expected_results.size());
         mismatches += expected_results.size();
      end
      if (mismatches == 0)
         $display("moving_average_cross_detector_tb: PASS");
      else
         $display("moving_average_cross_detector_tb: FAIL");
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("timeout with %0d of %0d responses checked", rsp_taken, req_taken);
      $display("moving_average_cross_detector_tb: FAIL");
      $finish;
   end

endmodule
